>>> sv/motor_dead_zone_pwm_split_top_macros.svh
// assertion macros shared by the dead-zone pwm split block
`ifndef MOTOR_DEAD_ZONE_PWM_SPLIT_TOP_MACROS_SVH
`define MOTOR_DEAD_ZONE_PWM_SPLIT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MDZ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdz: same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define MDZ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdz: next-cycle check failed");

`endif

>>> sv/mdz_pkg.sv
// shared constants, types and register codes for the dead-zone pwm split block
package mdz_pkg;

    // defaults for the top level parameters
    localparam int MAX_PULSE_DEF   = 3600;
    localparam int MOTOR_COUNT_DEF = 4;

    // fixed figures of the scheme
    localparam int DZ_REGS  = 4;
    localparam int BAT_LOW  = 50;
    localparam int BAT_HIGH = 200;
    localparam int MV_SCALE = 100;

    // field widths
    localparam int DZ_W    = 13;
    localparam int MODE_W  = 2;
    localparam int BAT_W   = 10;
    localparam int NOM_W   = 8;
    localparam int FIX_W   = 12;
    localparam int CMD_W   = 13;
    localparam int MOTOR_W = 3;
    localparam int CMP_W   = 12;
    localparam int DIV_W   = 15;
    localparam int IDX_W   = 3;

    // chassis mode codes; the unused code behaves as normal
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_DEAD_ZONE_M0 = 3'd0,
        CFG_DEAD_ZONE_M1 = 3'd1,
        CFG_DEAD_ZONE_M2 = 3'd2,
        CFG_DEAD_ZONE_M3 = 3'd3,
        CFG_CHASSIS_MODE = 3'd4,
        CFG_NOMINAL_BAT  = 3'd5,
        CFG_FIXED_OFFSET = 3'd6
    } cfg_idx_t;

    // register file contents handed to the datapath
    typedef struct packed {
        logic [DZ_REGS-1:0][DZ_W-1:0] dead_zone;
        logic [MODE_W-1:0]            chassis_mode;
        logic [NOM_W-1:0]             nominal_battery;
        logic [FIX_W-1:0]             fixed_offset;
    } mdz_cfg_t;

    // per-request data that rides alongside the divider
    typedef struct packed {
        logic [MOTOR_W-1:0]      motor;
        logic                    drive;
        logic signed [CMD_W-1:0] cmd;
    } mdz_side_t;

endpackage

>>> sv/mdz_prep.sv
// front stage: battery check, breakaway select and divider operands
module mdz_prep
    import mdz_pkg::*;
#(
    parameter int MAX_PULSE   = MAX_PULSE_DEF,
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    parameter int NW          = DZ_W + $clog2(MAX_PULSE + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mdz_cfg_t                cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MOTOR_W-1:0]      motor_sel,
    input  logic signed [CMD_W-1:0] speed_cmd,
    input  logic [BAT_W-1:0]        battery_tenths,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [NW-1:0]           out_num,
    output logic [DIV_W-1:0]        out_div,
    output mdz_side_t               out_side
);

    localparam int MOTOR_LIM = (MOTOR_COUNT < DZ_REGS) ? MOTOR_COUNT : DZ_REGS;

    logic             vld_reg;
    logic [NW-1:0]    num_reg, num_next;
    logic [DIV_W-1:0] div_reg, div_next;
    mdz_side_t        side_reg, side_next;
    logic             bat_ok;
    logic [NOM_W-1:0] nom_sat;
    logic [NOM_W-1:0] volts;
    logic [DZ_W-1:0]  dz_sel;

    // operands: breakaway times max pulse over volts times scale
    always_comb
    begin
        bat_ok  = (battery_tenths >= BAT_W'(BAT_LOW)) && (battery_tenths <= BAT_W'(BAT_HIGH));
        nom_sat = cfg.nominal_battery;
        if (cfg.nominal_battery < NOM_W'(BAT_LOW))
        begin
            nom_sat = NOM_W'(BAT_LOW);
        end
        else if (cfg.nominal_battery > NOM_W'(BAT_HIGH))
        begin
            nom_sat = NOM_W'(BAT_HIGH);
        end
        volts = bat_ok ? battery_tenths[NOM_W-1:0] : nom_sat;

        side_next.motor = motor_sel;
        side_next.drive = (motor_sel < MOTOR_W'(MOTOR_LIM));
        side_next.cmd   = speed_cmd;
        dz_sel          = side_next.drive ? cfg.dead_zone[motor_sel[1:0]] : '0;

        num_next = NW'(dz_sel) * NW'(MAX_PULSE);
        div_next = DIV_W'(volts) * DIV_W'(MV_SCALE);
    end

    assign in_ready = !vld_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            num_reg  <= num_next;
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

>>> sv/mdz_div.sv
// pipelined restoring divider, one quotient bit per stage
module mdz_div
    import mdz_pkg::*;
#(
    parameter int NW = 29,
    parameter int QW = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NW-1:0]    in_num,
    input  logic [DIV_W-1:0] in_div,
    input  mdz_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QW-1:0]    out_quot,
    output mdz_side_t        out_side
);

    localparam int CW = ((NW > DIV_W + QW) ? NW : DIV_W + QW) + 1;

    logic             vld_reg  [QW];
    logic [NW-1:0]    rem_reg  [QW];
    logic [DIV_W-1:0] div_reg  [QW];
    logic [QW-1:0]    quot_reg [QW];
    mdz_side_t        side_reg [QW];
    logic [QW:0]      rdy;

    assign rdy[QW] = out_ready;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic             st_vld;
        logic [NW-1:0]    st_rem;
        logic [DIV_W-1:0] st_div;
        logic [QW-1:0]    st_quot;
        mdz_side_t        st_side;
        logic [CW-1:0]    rem_ext;
        logic [CW-1:0]    sub_ext;
        logic [CW-1:0]    diff;
        logic             fits;
        logic [NW-1:0]    rem_next;
        logic [QW-1:0]    quot_next;

        // stage input comes from the ports or the stage before
        if (k == 0)
        begin : g_first
            assign st_vld  = in_valid;
            assign st_rem  = in_num;
            assign st_div  = in_div;
            assign st_quot = '0;
            assign st_side = in_side;
        end
        else
        begin : g_next
            assign st_vld  = vld_reg[k-1];
            assign st_rem  = rem_reg[k-1];
            assign st_div  = div_reg[k-1];
            assign st_quot = quot_reg[k-1];
            assign st_side = side_reg[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb
        begin
            rem_ext   = CW'(st_rem);
            sub_ext   = CW'(st_div) << BIT;
            diff      = rem_ext - sub_ext;
            fits      = (rem_ext >= sub_ext);
            rem_next  = fits ? diff[NW-1:0] : st_rem;
            quot_next = st_quot;
            quot_next[BIT] = fits;
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= st_vld;
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (rdy[k] && st_vld)
            begin
                rem_reg[k]  <= rem_next;
                div_reg[k]  <= st_div;
                quot_reg[k] <= quot_next;
                side_reg[k] <= st_side;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> sv/mdz_post.sv
// back stages: offset add, direction, saturation and h-bridge split
module mdz_post
    import mdz_pkg::*;
#(
    parameter int MAX_PULSE = MAX_PULSE_DEF,
    parameter int QW        = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mdz_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [QW-1:0]      in_quot,
    input  mdz_side_t          in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MOTOR_W-1:0] motor_out,
    output logic               drive_valid,
    output logic [CMP_W-1:0]   compare_a,
    output logic [CMP_W-1:0]   compare_b
);

    localparam int PW  = $clog2(MAX_PULSE + 1);
    localparam int XW0 = (QW > PW) ? QW : PW;
    localparam int XW1 = (XW0 > FIX_W) ? XW0 : FIX_W;
    localparam int XW  = (XW1 > CMD_W) ? XW1 : CMD_W;
    localparam int SW  = XW + 2;

    // stage a: compensated command
    logic                    a_vld_reg;
    logic signed [SW-1:0]    a_sum_reg, a_sum_next;
    logic                    a_flip_reg, a_flip_next;
    logic                    a_drive_reg;
    logic [MOTOR_W-1:0]      a_motor_reg;
    logic                    a_rdy;
    logic [XW-1:0]           quot_x;
    logic [XW-1:0]           offset;
    logic signed [SW-1:0]    cmd_x;
    logic signed [SW-1:0]    off_x;

    // stage b: result register
    logic                    b_vld_reg;
    logic [MOTOR_W-1:0]      b_motor_reg;
    logic                    b_drive_reg;
    logic [CMP_W-1:0]        b_cmp_a_reg, b_cmp_a_next;
    logic [CMP_W-1:0]        b_cmp_b_reg, b_cmp_b_next;
    logic                    b_rdy;
    logic                    neg;
    logic                    neg_final;
    logic [SW-1:0]           abs_sum;
    logic [SW-1:0]           mag;

    // offset choice and add away from zero
    always_comb
    begin
        quot_x = XW'(in_quot);
        if (cfg.chassis_mode == MODE_FIXED)
        begin
            offset = XW'(cfg.fixed_offset);
        end
        else if (quot_x > XW'(MAX_PULSE - 1))
        begin
            offset = XW'(MAX_PULSE - 1);
        end
        else
        begin
            offset = quot_x;
        end
        cmd_x = SW'(in_side.cmd);
        off_x = $signed({2'b00, offset});
        if (in_side.cmd > 0)
        begin
            a_sum_next = cmd_x + off_x;
        end
        else if (in_side.cmd < 0)
        begin
            a_sum_next = cmd_x - off_x;
        end
        else
        begin
            a_sum_next = '0;
        end
        // four-wheel flip and the inverted motors fold into one sign change
        a_flip_next = (cfg.chassis_mode == MODE_FLIP) ^ (in_side.motor[MOTOR_W-1:1] == '0);
    end

    assign b_rdy    = !b_vld_reg || out_ready;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (a_rdy)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_sum_reg   <= a_sum_next;
            a_flip_reg  <= a_flip_next;
            a_drive_reg <= in_side.drive;
            a_motor_reg <= in_side.motor;
        end
    end

    // saturate magnitude and split onto the two bridge sides
    always_comb
    begin
        neg       = a_sum_reg[SW-1];
        abs_sum   = neg ? SW'(-a_sum_reg) : SW'(a_sum_reg);
        mag       = (abs_sum > SW'(MAX_PULSE)) ? SW'(MAX_PULSE) : abs_sum;
        neg_final = neg ^ a_flip_reg;
        b_cmp_a_next = (a_drive_reg && !neg_final) ? mag[CMP_W-1:0] : '0;
        b_cmp_b_next = (a_drive_reg && neg_final) ? mag[CMP_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (b_rdy)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && a_vld_reg)
        begin
            b_motor_reg <= a_motor_reg;
            b_drive_reg <= a_drive_reg;
            b_cmp_a_reg <= b_cmp_a_next;
            b_cmp_b_reg <= b_cmp_b_next;
        end
    end

    assign out_valid   = b_vld_reg;
    assign motor_out   = b_motor_reg;
    assign drive_valid = b_drive_reg;
    assign compare_a   = b_cmp_a_reg;
    assign compare_b   = b_cmp_b_reg;

endmodule

>>> sv/motor_dead_zone_pwm_split_top.sv
// top level of the motor dead-zone compensation and h-bridge pwm split
//
// channel  direction  handshake                   payload
// s_axis   in         s_tvalid / s_tready         s_tdata: motor, speed, battery
// m_axis   out        m_tvalid / m_tready         m_tdata: motor, drive, compare a/b
// cfg      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one request per cycle sustained while m_tready stays high; the restoring divider
// between the operand and back stages resolves one quotient bit per stage
// reset clears every stage valid and loads the register reset values
// each stage holds while its successor is full and stalled; empty stages fill
// behind a stalled output, so s_tready falls only once the whole pipe is full
// cfg_ready is always high; writes take effect the next cycle
`include "motor_dead_zone_pwm_split_top_macros.svh"

module motor_dead_zone_pwm_split_top
    import mdz_pkg::*;
#(
    parameter int MAX_PULSE   = MAX_PULSE_DEF,
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [2:0] motor_sel, [15:3] speed_cmd, [25:16] battery_tenths, [31:26] zero
    input  logic [31:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [2:0] motor_out, [3] drive_valid, [15:4] compare_a, [27:16] compare_b, [31:28] zero
    output logic [31:0]       m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DZ_W-1:0]   cfg_data
);

    localparam int PW   = $clog2(MAX_PULSE + 1);
    localparam int NW   = DZ_W + PW;
    localparam int QMAX = ((2 ** DZ_W - 1) * MAX_PULSE) / (BAT_LOW * MV_SCALE);
    localparam int QW   = $clog2(QMAX + 1);

    // configuration registers
    logic [DZ_REGS-1:0][DZ_W-1:0] dead_zone_reg;
    logic [MODE_W-1:0]            chassis_mode_reg;
    logic [NOM_W-1:0]             nominal_battery_reg;
    logic [FIX_W-1:0]             fixed_offset_reg;
    mdz_cfg_t                     cfg;

    // datapath links
    logic               prep_valid, prep_ready;
    logic [NW-1:0]      prep_num;
    logic [DIV_W-1:0]   prep_div;
    mdz_side_t          prep_side;
    logic               div_valid, div_ready;
    logic [QW-1:0]      div_quot;
    mdz_side_t          div_side;
    logic [MOTOR_W-1:0] motor_out;
    logic               drive_valid;
    logic [CMP_W-1:0]   compare_a;
    logic [CMP_W-1:0]   compare_b;
    logic               mode_write;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg       <= '0;
            chassis_mode_reg    <= MODE_NORMAL;
            nominal_battery_reg <= NOM_W'(120);
            fixed_offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEAD_ZONE_M0: dead_zone_reg[0]    <= cfg_data;
                CFG_DEAD_ZONE_M1: dead_zone_reg[1]    <= cfg_data;
                CFG_DEAD_ZONE_M2: dead_zone_reg[2]    <= cfg_data;
                CFG_DEAD_ZONE_M3: dead_zone_reg[3]    <= cfg_data;
                CFG_CHASSIS_MODE: chassis_mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_NOMINAL_BAT:  nominal_battery_reg <= cfg_data[NOM_W-1:0];
                CFG_FIXED_OFFSET: fixed_offset_reg    <= cfg_data[FIX_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.dead_zone       = dead_zone_reg;
    assign cfg.chassis_mode    = chassis_mode_reg;
    assign cfg.nominal_battery = nominal_battery_reg;
    assign cfg.fixed_offset    = fixed_offset_reg;

    // operand stage
    mdz_prep #(
        .MAX_PULSE   (MAX_PULSE),
        .MOTOR_COUNT (MOTOR_COUNT),
        .NW          (NW)
    ) u_prep (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .motor_sel      (s_tdata[2:0]),
        .speed_cmd      ($signed(s_tdata[15:3])),
        .battery_tenths (s_tdata[25:16]),
        .out_valid      (prep_valid),
        .out_ready      (prep_ready),
        .out_num        (prep_num),
        .out_div        (prep_div),
        .out_side       (prep_side)
    );

    // divider pipe
    mdz_div #(
        .NW (NW),
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_num    (prep_num),
        .in_div    (prep_div),
        .in_side   (prep_side),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // offset, saturation and split
    mdz_post #(
        .MAX_PULSE (MAX_PULSE),
        .QW        (QW)
    ) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (div_valid),
        .in_ready    (div_ready),
        .in_quot     (div_quot),
        .in_side     (div_side),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .motor_out   (motor_out),
        .drive_valid (drive_valid),
        .compare_a   (compare_a),
        .compare_b   (compare_b)
    );

    assign m_tdata = {4'b0000, compare_b, compare_a, drive_valid, motor_out};

    // checks
    assign mode_write = cfg_valid && cfg_ready && (cfg_index == CFG_CHASSIS_MODE);

    `MDZ_ASSERT_IMP(a_no_drive_zero, m_tvalid && !drive_valid, compare_a == '0 && compare_b == '0)
    `MDZ_ASSERT_IMP(a_one_side, m_tvalid, compare_a == '0 || compare_b == '0)
    `MDZ_ASSERT_IMP(a_ready_chain, m_tready, s_tready)
    `MDZ_ASSERT_NXT(a_mode_write, mode_write, chassis_mode_reg == $past(cfg_data[MODE_W-1:0]))

endmodule
